// ===== hw/rtl/slist_pkg.sv =====
// Package for the shifting list block: field widths, command and status codes,
// and the control struct broadcast to the entry cells. No dependencies.
package slist_pkg;

   localparam int DEPTH_DEFAULT  = 16;
   localparam int ELEM_W_DEFAULT = 32;

   localparam int CMD_W    = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 4;
   localparam int COUNT_W  = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   // broadcast to every cell in the accept cycle
   typedef struct packed {
      logic             ins;
      logic             del;
      logic [POS_W-1:0] pos;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/shifting_list_insert_delete_search.sv =====
// Channel | Direction | Ports
// req     | in        | req_valid, req_stall, req_command, req_value, req_position
// rsp     | out       | rsp_valid, rsp_stall, rsp_status, rsp_found_index,
//         |           | rsp_read_value, rsp_entry_count
//
// One request per cycle while req_stall is low; each response passes the stage-one and output registers.
// Stage one updates the cell row and registers the match vector and read data;
// stage two encodes the lowest match into the output register.
// Synchronous reset empties the list (count zero); entries are left as they are.
// rsp_stall holds the output register; req_stall rises only when both stages are full.
// Depends on slist_pkg, slist_cell, slist_penc.
module shifting_list_insert_delete_search
   import slist_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEFAULT,
   parameter int ELEM_W = ELEM_W_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CMD_W-1:0]           req_command,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [POS_W-1:0]           req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [FOUND_W-1:0]         rsp_found_index,
   output logic signed [VALUE_W-1:0]  rsp_read_value,
   output logic [COUNT_W-1:0]         rsp_entry_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int XW    = CNT_W + POS_W;

   // list count
   logic [CNT_W-1:0]  count_ff, count_in;

   // stage one
   logic              s1_valid_ff, s1_valid_in;
   status_type        s1_status_ff, s1_status_in;
   logic              s1_search_ff, s1_search_in;
   logic [DEPTH-1:0]  s1_match_ff;
   logic [ELEM_W-1:0] s1_rdata_ff, s1_rdata_in;
   logic [CNT_W-1:0]  s1_count_ff;

   // output register
   logic               out_valid_ff, out_valid_in;
   status_type         out_status_ff, out_status_in;
   logic [FOUND_W-1:0] out_found_ff, out_found_in;
   logic [VALUE_W-1:0] out_rdata_ff, out_rdata_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;

   logic              req_acc, s1_adv, full, read_ok;
   cmd_type           cmd;
   cell_ctrl_type     ctrl;
   logic [XW-1:0]     pos_x, cnt_x;
   logic [ELEM_W+VALUE_W-1:0] val_sx;
   logic [ELEM_W-1:0] val;
   logic [ELEM_W-1:0] cell_q [DEPTH];
   logic [DEPTH-1:0]  hit, sel, live;
   logic [ELEM_W-1:0] rd_or;
   logic              pe_any;
   logic [IDX_W-1:0]  pe_idx;
   logic [IDX_W+FOUND_W-1:0]  found_x;
   logic [ELEM_W+VALUE_W-1:0] rdata_x;
   logic [CNT_W+COUNT_W-1:0]  count_x;

   assign s1_adv    = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_acc   = req_valid && !req_stall;

   assign cmd    = cmd_type'(req_command);
   assign val_sx = {{ELEM_W{req_value[VALUE_W-1]}}, req_value};
   assign val    = val_sx[ELEM_W-1:0];
   assign pos_x  = XW'(req_position);
   assign cnt_x  = XW'(count_ff);
   assign full   = (count_ff == CNT_W'(DEPTH));

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic [ELEM_W-1:0] prev_e, next_e;
         if (g == 0) begin : g_first
            assign prev_e = '0;
         end else begin : g_mid
            assign prev_e = cell_q[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign next_e = cell_q[g];
         end else begin : g_inner
            assign next_e = cell_q[g+1];
         end
         assign live[g] = (cnt_x > XW'(g));

         slist_cell #(
            .DEPTH  (DEPTH),
            .ELEM_W (ELEM_W),
            .INDEX  (g)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .value      (val),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .entry      (cell_q[g]),
            .hit        (hit[g]),
            .sel        (sel[g])
         );
      end
   endgenerate

   // one-hot select of the addressed entry
   always_comb begin
      rd_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_or = rd_or | (sel[i] ? cell_q[i] : '0);
      end
   end

   always_comb begin
      ctrl         = '0;
      ctrl.pos     = req_position;
      count_in     = count_ff;
      s1_status_in = ST_OK;
      s1_search_in = 1'b0;
      read_ok      = 1'b0;
      unique case (cmd)
         CMD_INSERT: begin
            if (full) begin
               s1_status_in = ST_FULL;
            end else if (pos_x > cnt_x) begin
               s1_status_in = ST_RANGE;
            end else begin
               ctrl.ins = req_acc;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_DELETE: begin
            if (pos_x >= cnt_x) begin
               s1_status_in = ST_RANGE;
            end else begin
               ctrl.del = req_acc;
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_SEARCH: begin
            s1_search_in = 1'b1;
         end
         CMD_READ: begin
            if (pos_x >= cnt_x) begin
               s1_status_in = ST_RANGE;
            end else begin
               read_ok = 1'b1;
            end
         end
         default: begin
            s1_status_in = ST_RANGE;
         end
      endcase
      s1_rdata_in = read_ok ? rd_or : '0;
      s1_valid_in = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (req_acc) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_status_ff <= s1_status_in;
         s1_search_ff <= s1_search_in;
         s1_match_ff  <= hit & live;
         s1_rdata_ff  <= s1_rdata_in;
         s1_count_ff  <= count_in;
      end
   end

   slist_penc #(
      .DEPTH (DEPTH)
   ) u_penc (
      .match (s1_match_ff),
      .any   (pe_any),
      .index (pe_idx)
   );

   always_comb begin
      found_x       = '0;
      out_status_in = s1_status_ff;
      if (s1_search_ff) begin
         if (pe_any) begin
            out_status_in = ST_OK;
            found_x       = (IDX_W + FOUND_W)'(pe_idx);
         end else begin
            out_status_in = ST_NOT_FOUND;
         end
      end
      out_found_in = found_x[FOUND_W-1:0];
      rdata_x      = (ELEM_W + VALUE_W)'(s1_rdata_ff);
      out_rdata_in = rdata_x[VALUE_W-1:0];
      count_x      = (CNT_W + COUNT_W)'(s1_count_ff);
      out_count_in = count_x[COUNT_W-1:0];
      out_valid_in = s1_adv ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         out_status_ff <= out_status_in;
         out_found_ff  <= out_found_in;
         out_rdata_ff  <= out_rdata_in;
         out_count_ff  <= out_count_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_found_index = out_found_ff;
   assign rsp_read_value  = out_rdata_ff;
   assign rsp_entry_count = out_count_ff;

endmodule

// ===== hw/rtl/slist_cell.sv =====
// One entry cell of the shifting list: holds an entry, shifts to or from its
// neighbors on insert/delete, compares against the key. Depends on slist_pkg.
module slist_cell
   import slist_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEFAULT,
   parameter int ELEM_W = ELEM_W_DEFAULT,
   parameter int INDEX  = 0
) (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [ELEM_W-1:0] value,
   input  logic [ELEM_W-1:0] prev_entry,
   input  logic [ELEM_W-1:0] next_entry,
   output logic [ELEM_W-1:0] entry,
   output logic              hit,
   output logic              sel
);

   localparam int XW = $clog2(DEPTH + 1) + POS_W;
   localparam logic [XW-1:0] IDX_X = XW'(INDEX);

   logic [ELEM_W-1:0] entry_ff;
   logic [ELEM_W-1:0] entry_in;
   logic [XW-1:0]     pos_x;

   assign pos_x = XW'(ctrl.pos);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins && (IDX_X > pos_x)) begin
         entry_in = prev_entry;
      end else if (ctrl.ins && (IDX_X == pos_x)) begin
         entry_in = value;
      end else if (ctrl.del && (IDX_X >= pos_x)) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign hit   = (entry_ff == value);
   assign sel   = (IDX_X == pos_x);

endmodule

// ===== hw/rtl/slist_penc.sv =====
// Lowest-set-bit encoder for the registered search match vector.
// Depends on slist_pkg.
module slist_penc
   import slist_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic [DEPTH-1:0]         match,
   output logic                     any,
   output logic [$clog2(DEPTH)-1:0] index
);

   localparam int IDX_W = $clog2(DEPTH);

   logic [DEPTH-1:0] lowest;

   // isolate the lowest set bit, then OR the indexes of the one-hot word
   assign lowest = match & (~match + DEPTH'(1));
   assign any    = |match;

   always_comb begin
      index = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (lowest[i]) begin
            index = index | IDX_W'(i);
         end
      end
   end

endmodule

// ===== hw/rtl/slist_check.sv =====
// Port-level checks on the shifting list responses, bound to the top level.
// Depends on slist_pkg and shifting_list_insert_delete_search.
module slist_check
   import slist_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [STATUS_W-1:0]       rsp_status,
   input logic [FOUND_W-1:0]        rsp_found_index,
   input logic signed [VALUE_W-1:0] rsp_read_value,
   input logic [COUNT_W-1:0]        rsp_entry_count
);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= DEPTH))
      else $error("entry count above depth");

   // a full status is only reported on a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_entry_count == COUNT_W'(DEPTH)))
      else $error("full status with list not full");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |->
         ((rsp_found_index == '0) && (rsp_read_value == '0)))
      else $error("failed request carries data");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_found_index)
          && $stable(rsp_read_value) && $stable(rsp_entry_count)))
      else $error("stalled response changed");

endmodule

bind shifting_list_insert_delete_search slist_check #(.DEPTH(DEPTH)) u_slist_check (.*);
